// ===== hdl/hslpwm_pkg.sv =====
// Package for the HSL to RGB soft PWM core: field widths, Q16 constants,
// step counts of the serial divider and multiplier, and the sequencer state type.
// No dependencies.
package hslpwm_pkg;

    // Field widths
    localparam int HUE_W        = 9;
    localparam int SL_W         = 9;
    localparam int LVL_W        = 8;
    localparam int PWM_BITS_DEF = 8;

    // Q16 fixed point; values up to 1.0 need 17 bits
    localparam int Q_FRAC = 16;
    localparam int Q_W    = Q_FRAC + 1;
    localparam int X_W    = Q_W + 1;

    localparam logic [Q_W-1:0] Q_ONE        = 17'd65536;
    localparam logic [Q_W-1:0] Q_HALF       = 17'd32768;
    localparam logic [Q_W-1:0] Q_THIRD      = 17'd21845;
    localparam logic [Q_W-1:0] Q_TWO_THIRDS = 17'd43690;

    // Saturation and lightness of 1.0, and the lightness of one half
    localparam logic [SL_W-1:0] UNIT_MAX = 9'd256;
    localparam logic [SL_W-1:0] LIG_HALF = 9'd128;

    // Hue scaling: h = (hue << 16) / 360, one quotient bit per step
    localparam int              DIV_W     = HUE_W + Q_FRAC;
    localparam int              DIV_STEPS = DIV_W;
    localparam logic [HUE_W:0]  HUE_DIV   = 10'd360;

    // Shift-add multiplier: 17-bit multiplicand, 16-bit multiplier
    localparam int MUL_A_W   = Q_W;
    localparam int MUL_B_W   = Q_FRAC;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_STEPS = MUL_B_W;

    localparam int                CNT_W    = 5;
    localparam logic [CNT_W-1:0]  DIV_LAST = 5'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0]  MUL_LAST = 5'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0]  MUL_END  = 5'(MUL_STEPS);

    // Channel indexes
    localparam int         NUM_CH   = 3;
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_PREP,
        ST_MIX,
        ST_CHAN,
        ST_MUL,
        ST_LEVEL,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/hsl_to_rgb_soft_pwm_core.sv =====
// HSL to RGB converter with three-channel soft PWM. A tick request compares the
// stored red, green and blue levels with a free-running PWM_BITS counter and then
// advances it; a set-colour request runs hue, saturation and lightness through the
// HSL formula in Q16 fixed point and stores three new levels. One request is worked
// at a time; the result sits in an output register, so the next request is taken
// while the previous result still waits. A tick is worked in ST_TICK, which writes
// its result once the output register is free and then returns to idle. A
// set-colour request runs the bit-serial hue divider (one quotient bit per
// cycle, with lightness times saturation formed alongside on the shift-add
// multiplier), forms the two HSL corner values, then per channel runs the 16 steps
// of the shared shift-add multiplier and scales a level, and commits on a free output.
// Depends on hslpwm_pkg.
module hsl_to_rgb_soft_pwm_core
    import hslpwm_pkg::*;
#(
    parameter int PWM_BITS = PWM_BITS_DEF
)(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic             command,
    input  logic [HUE_W-1:0] hue,
    input  logic [SL_W-1:0]  saturation,
    input  logic [SL_W-1:0]  lightness,

    output logic             out_valid,
    input  logic             out_stall,
    output logic             red_on,
    output logic             green_on,
    output logic             blue_on,
    output logic [LVL_W-1:0] red_level,
    output logic [LVL_W-1:0] green_level,
    output logic [LVL_W-1:0] blue_level
);

    localparam logic [PWM_BITS-1:0] FULL_SCALE = {PWM_BITS{1'b1}};

    // Sequencer and control state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         chan_reg, chan_next;
    logic [PWM_BITS-1:0] pwm_cnt_reg, pwm_cnt_next;
    logic [PWM_BITS-1:0] lvl_reg [NUM_CH];
    logic [PWM_BITS-1:0] lvl_next [NUM_CH];
    logic               out_valid_reg, out_valid_next;

    // Datapath registers
    logic [SL_W-1:0]    lig_reg, lig_next;
    logic [SL_W-1:0]    sat_reg, sat_next;
    logic [DIV_W-1:0]   div_dvd_reg, div_dvd_next;
    logic [HUE_W-1:0]   div_rem_reg, div_rem_next;
    logic [Q_W-1:0]     div_q_reg, div_q_next;
    logic [MUL_A_W-1:0] mul_a_reg, mul_a_next;
    logic [MUL_P_W-1:0] mul_p_reg, mul_p_next;
    logic [Q_W-1:0]     v1_reg, v1_next;
    logic [Q_W-1:0]     v2_reg, v2_next;
    logic [Q_W-1:0]     diff_reg, diff_next;
    logic [Q_W-1:0]     base_reg, base_next;
    logic [PWM_BITS-1:0] new_lvl_reg [NUM_CH];
    logic [PWM_BITS-1:0] new_lvl_next [NUM_CH];
    logic               out_on_reg [NUM_CH];
    logic               out_on_next [NUM_CH];
    logic [LVL_W-1:0]   out_lvl_reg [NUM_CH];
    logic [LVL_W-1:0]   out_lvl_next [NUM_CH];

    // Handshake
    logic in_fire;
    logic out_free;

    // Clamped inputs
    logic [SL_W-1:0] sat_clamp;
    logic [SL_W-1:0] lig_clamp;

    // Serial divider step
    logic [HUE_W:0]   div_r2;
    logic             div_ge;
    logic [HUE_W-1:0] div_rem_step;

    // Serial multiplier step
    logic [MUL_A_W:0]   mul_sum;
    logic [MUL_P_W-1:0] mul_step;

    // Corner values
    logic [Q_W-1:0] l_q;
    logic [Q_W-1:0] s_q;
    logic [X_W-1:0] v2_wide;
    logic [X_W-1:0] v1_wide;

    // Per-channel hue position and ramp factor
    logic [X_W-1:0]     vh_pre;
    logic [Q_W-1:0]     vh;
    logic [Q_W+2:0]     six_vh;
    logic [Q_W+2:0]     three_vh;
    logic [Q_W-1:0]     ramp_t;
    logic [Q_W+2:0]     six_t;
    logic [Q_W-1:0]     base_sel;
    logic [MUL_B_W-1:0] factor_sel;

    // Level scaling
    logic [X_W-1:0]            x_val;
    logic [X_W+PWM_BITS-1:0]   scaled;
    logic [PWM_BITS+1:0]       lvl_wide;
    logic [PWM_BITS-1:0]       lvl_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign red_on      = out_on_reg[CH_RED];
    assign green_on    = out_on_reg[CH_GREEN];
    assign blue_on     = out_on_reg[CH_BLUE];
    assign red_level   = out_lvl_reg[CH_RED];
    assign green_level = out_lvl_reg[CH_GREEN];
    assign blue_level  = out_lvl_reg[CH_BLUE];

    // Saturation and lightness above 1.0 are taken as 1.0
    assign sat_clamp = (saturation > UNIT_MAX) ? UNIT_MAX : saturation;
    assign lig_clamp = (lightness > UNIT_MAX) ? UNIT_MAX : lightness;

    // Restoring division by 360: bring in one dividend bit, subtract if it fits
    assign div_r2       = {div_rem_reg, div_dvd_reg[DIV_W-1]};
    assign div_ge       = (div_r2 >= HUE_DIV);
    assign div_rem_step = div_ge ? HUE_W'(div_r2 - HUE_DIV) : div_r2[HUE_W-1:0];

    // Shift-add multiply: add the multiplicand on a set LSB, then shift right
    assign mul_sum  = {1'b0, mul_p_reg[MUL_P_W-1:MUL_B_W]}
                    + (mul_p_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign mul_step = {mul_sum, mul_p_reg[MUL_B_W-1:1]};

    // Corner values of the HSL formula. With lightness and saturation in 1/256
    // units, floor(l*s/65536) is exactly lig*sat, which the multiplier holds.
    assign l_q     = {lig_reg, 8'b0};
    assign s_q     = {sat_reg, 8'b0};
    assign v2_wide = (l_q < Q_HALF)
                   ? ({1'b0, l_q} + {1'b0, mul_p_reg[Q_W-1:0]})
                   : ({1'b0, l_q} + {1'b0, s_q} - {1'b0, mul_p_reg[Q_W-1:0]});
    assign v1_wide = {l_q, 1'b0} - v2_wide;

    // Hue position of the current channel, shifted by a third and wrapped once
    always_comb
    begin
        case (chan_reg)
            CH_RED:
            begin
                vh_pre = {1'b0, div_q_reg} + {1'b0, Q_THIRD};
            end
            CH_GREEN:
            begin
                vh_pre = {1'b0, div_q_reg};
            end
            CH_BLUE:
            begin
                if (div_q_reg < Q_THIRD)
                begin
                    vh_pre = {1'b0, div_q_reg} + {1'b0, Q_ONE} - {1'b0, Q_THIRD};
                end
                else
                begin
                    vh_pre = {1'b0, div_q_reg} - {1'b0, Q_THIRD};
                end
            end
            default:
            begin
                vh_pre = '0;
            end
        endcase
    end

    assign vh       = (vh_pre > {1'b0, Q_ONE}) ? Q_W'(vh_pre - {1'b0, Q_ONE})
                                                : vh_pre[Q_W-1:0];
    assign six_vh   = ({3'b0, vh} << 2) + ({3'b0, vh} << 1);
    assign three_vh = ({3'b0, vh} << 1) + {3'b0, vh};
    assign ramp_t   = (vh > Q_TWO_THIRDS) ? '0 : (Q_TWO_THIRDS - vh);
    assign six_t    = ({3'b0, ramp_t} << 2) + ({3'b0, ramp_t} << 1);

    // Pick the segment: rising ramp, flat top, falling ramp, or flat bottom.
    // Every segment becomes base + diff * factor / 65536.
    always_comb
    begin
        if (six_vh < {3'b0, Q_ONE})
        begin
            base_sel   = v1_reg;
            factor_sel = six_vh[MUL_B_W-1:0];
        end
        else if (({3'b0, vh} << 1) < {3'b0, Q_ONE})
        begin
            base_sel   = v2_reg;
            factor_sel = '0;
        end
        else if (three_vh < ({3'b0, Q_ONE} << 1))
        begin
            base_sel   = v1_reg;
            factor_sel = six_t[MUL_B_W-1:0];
        end
        else
        begin
            base_sel   = v1_reg;
            factor_sel = '0;
        end
    end

    // Level = floor(x * FS / 65536), with x * FS formed as (x << PWM_BITS) - x
    assign x_val    = {1'b0, base_reg} + {1'b0, mul_p_reg[MUL_P_W-1:MUL_B_W]};
    assign scaled   = {x_val, {PWM_BITS{1'b0}}} - {{PWM_BITS{1'b0}}, x_val};
    assign lvl_wide = scaled[X_W+PWM_BITS-1:Q_FRAC];
    assign lvl_sat  = (lvl_wide > {2'b00, FULL_SCALE}) ? FULL_SCALE
                                                       : lvl_wide[PWM_BITS-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = command ? ST_PREP : ST_TICK;
                end
            end
            ST_TICK:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL:
            begin
                state_next = (chan_reg == CH_BLUE) ? ST_DONE : ST_CHAN;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output updates per state
    always_comb
    begin
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        pwm_cnt_next   = pwm_cnt_reg;
        lig_next       = lig_reg;
        sat_next       = sat_reg;
        div_dvd_next   = div_dvd_reg;
        div_rem_next   = div_rem_reg;
        div_q_next     = div_q_reg;
        mul_a_next     = mul_a_reg;
        mul_p_next     = mul_p_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        diff_next      = diff_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && out_stall;
        for (int i = 0; i < NUM_CH; i++)
        begin
            lvl_next[i]     = lvl_reg[i];
            new_lvl_next[i] = new_lvl_reg[i];
            out_on_next[i]  = out_on_reg[i];
            out_lvl_next[i] = out_lvl_reg[i];
        end

        case (state_reg)
            ST_IDLE:
            begin
                // Load the divider with hue << 16 and the multiplier with lig * sat
                if (in_fire && command)
                begin
                    lig_next     = lig_clamp;
                    sat_next     = sat_clamp;
                    div_dvd_next = {hue, {Q_FRAC{1'b0}}};
                    div_rem_next = '0;
                    div_q_next   = '0;
                    mul_a_next   = MUL_A_W'(lig_clamp);
                    mul_p_next   = {{MUL_A_W{1'b0}}, MUL_B_W'(sat_clamp)};
                    cnt_next     = '0;
                    chan_next    = CH_RED;
                end
            end
            ST_TICK:
            begin
                // Compare against the counter as it stands, then advance it
                if (out_free)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        out_on_next[i]  = (lvl_reg[i] > pwm_cnt_reg);
                        out_lvl_next[i] = LVL_W'(lvl_reg[i]);
                    end
                    pwm_cnt_next   = pwm_cnt_reg + 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            ST_PREP:
            begin
                div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
                div_rem_next = div_rem_step;
                div_q_next   = {div_q_reg[Q_W-2:0], div_ge};
                if (cnt_reg < MUL_END)
                begin
                    mul_p_next = mul_step;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_MIX:
            begin
                v2_next = v2_wide[Q_W-1:0];
                v1_next = v1_wide[Q_W-1:0];
            end
            ST_CHAN:
            begin
                // First pass through here also settles the spread
                if (chan_reg == CH_RED)
                begin
                    diff_next = v2_reg - v1_reg;
                end
                base_next  = base_sel;
                mul_a_next = (chan_reg == CH_RED) ? (v2_reg - v1_reg) : diff_reg;
                mul_p_next = {{MUL_A_W{1'b0}}, factor_sel};
                cnt_next   = '0;
            end
            ST_MUL:
            begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_LEVEL:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    if (chan_reg == 2'(i))
                    begin
                        new_lvl_next[i] = lvl_sat;
                    end
                end
                if (chan_reg != CH_BLUE)
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                // Commit the new colour; a set-colour result never drives the pins
                if (out_free)
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        lvl_next[i]     = new_lvl_reg[i];
                        out_on_next[i]  = 1'b0;
                        out_lvl_next[i] = LVL_W'(new_lvl_reg[i]);
                    end
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            chan_reg      <= CH_RED;
            pwm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                lvl_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chan_reg      <= chan_next;
            pwm_cnt_reg   <= pwm_cnt_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_CH; i++)
            begin
                lvl_reg[i] <= lvl_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lig_reg     <= lig_next;
        sat_reg     <= sat_next;
        div_dvd_reg <= div_dvd_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        mul_a_reg   <= mul_a_next;
        mul_p_reg   <= mul_p_next;
        v1_reg      <= v1_next;
        v2_reg      <= v2_next;
        diff_reg    <= diff_next;
        base_reg    <= base_next;
        for (int i = 0; i < NUM_CH; i++)
        begin
            new_lvl_reg[i] <= new_lvl_next[i];
            out_on_reg[i]  <= out_on_next[i];
            out_lvl_reg[i] <= out_lvl_next[i];
        end
    end

endmodule

// ===== hdl/hslpwm_checker.sv =====
// Port-level checker for hsl_to_rgb_soft_pwm_core, with its bind statement.
// Depends on hslpwm_pkg.
module hslpwm_checker
    import hslpwm_pkg::*;
#(
    parameter int PWM_BITS = PWM_BITS_DEF
)(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             red_on,
    input logic             green_on,
    input logic             blue_on,
    input logic [LVL_W-1:0] red_level,
    input logic [LVL_W-1:0] green_level,
    input logic [LVL_W-1:0] blue_level
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pend_reg, pend_next;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // Requests accepted but not yet answered
    always_comb
    begin
        pend_next = pend_reg + 2'(in_fire) - 2'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(red_on) && $stable(green_on) && $stable(blue_on)
            && $stable(red_level) && $stable(green_level) && $stable(blue_level))
        else $error("result changed while stalled");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> pend_reg != 2'd0)
        else $error("result delivered with no request outstanding");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more requests in flight than the core can hold");

    a_on_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (PWM_BITS <= LVL_W)
            |-> (!red_on || red_level != '0) && (!green_on || green_level != '0)
                && (!blue_on || blue_level != '0))
        else $error("PWM output on with a zero level");

endmodule

bind hsl_to_rgb_soft_pwm_core hslpwm_checker #(.PWM_BITS(PWM_BITS)) u_hslpwm_checker (.*);

// ===== tb/tb_hsl_to_rgb_soft_pwm_core.sv =====
// Self-checking testbench for hsl_to_rgb_soft_pwm_core: drives tick and set-colour
// requests, predicts the PWM outputs and stored levels, and compares every result.
// Depends on hslpwm_pkg and hsl_to_rgb_soft_pwm_core.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_soft_pwm_core;
    import hslpwm_pkg::*;

    localparam int PWM_BITS = PWM_BITS_DEF;

    // Request codes on the command field
    localparam logic CMD_TICK      = 1'b0;
    localparam logic CMD_SET_COLOR = 1'b1;

    // Q16 constants for the color math, kept wide for 64-bit arithmetic
    localparam longint Q16_ONE        = 65536;
    localparam longint Q16_HALF       = 32768;
    localparam longint Q16_THIRD      = 21845;
    localparam longint Q16_TWO_THIRDS = 43690;
    localparam longint FULL_SCALE     = (longint'(1) << PWM_BITS) - 1;
    localparam longint UNIT           = 256;

    // Generous bound on the run, covering the serial set-colour work plus gaps and stalls
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic             red_on;
        logic             green_on;
        logic             blue_on;
        logic [LVL_W-1:0] red_level;
        logic [LVL_W-1:0] green_level;
        logic [LVL_W-1:0] blue_level;
    } rgb_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    logic [HUE_W-1:0] hue;
    logic [SL_W-1:0]  saturation;
    logic [SL_W-1:0]  lightness;
    logic             out_valid;
    logic             out_stall;
    logic             red_on;
    logic             green_on;
    logic             blue_on;
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;

    // Shadow state of the block: PWM counter and the three stored levels (R, G, B)
    int unsigned      pwm_count;
    int unsigned      rgb_level [3];
    rgb_result_t      queued_rgb [$];

    int               fail_count   = 0;
    int               cycle_count  = 0;
    bit               source_gaps  = 1'b0;
    bit               sink_gaps    = 1'b0;
    int               hold_request = 0;

    hsl_to_rgb_soft_pwm_core #(
        .PWM_BITS    (PWM_BITS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .hue         (hue),
        .saturation  (saturation),
        .lightness   (lightness),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_on      (red_on),
        .green_on    (green_on),
        .blue_on     (blue_on),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hsl_to_rgb_soft_pwm_core verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // Color prediction
    // ---------------------------------------------------------------------------

    // One channel of the HSL formula: position the hue on the ramp between the two
    // corner values lo and hi. The hue is wrapped only once in either direction.
    function automatic longint hsl_channel(longint lo, longint hi, longint hue_pos);
        longint span;
        longint fall;
        span = hi - lo;
        if (span < 0)
            span = 0;
        if (hue_pos < 0)
            hue_pos += Q16_ONE;
        if (hue_pos > Q16_ONE)
            hue_pos -= Q16_ONE;
        if (6 * hue_pos < Q16_ONE)
            return lo + ((span * (6 * hue_pos)) >>> 16);
        if (2 * hue_pos < Q16_ONE)
            return hi;
        if (3 * hue_pos < 2 * Q16_ONE)
        begin
            fall = Q16_TWO_THIRDS - hue_pos;
            if (fall < 0)
                fall = 0;
            return lo + ((span * (6 * fall)) >>> 16);
        end
        return lo;
    endfunction

    // Scale a Q16 value to a PWM level, truncating and saturating at full scale
    function automatic int unsigned q16_to_level(longint x);
        longint scaled;
        if (x < 0)
            x = 0;
        scaled = (x * FULL_SCALE) >>> 16;
        if (scaled > FULL_SCALE)
            scaled = FULL_SCALE;
        return int'(scaled);
    endfunction

    function automatic void mix_hsl_levels(logic [HUE_W-1:0] h_deg, logic [SL_W-1:0] s_in,
                                           logic [SL_W-1:0] l_in);
        longint s_u;
        longint l_u;
        longint sq;
        longint lq;
        longint hq;
        longint upper;
        longint lower;
        s_u = (s_in > UNIT) ? UNIT : longint'(s_in);
        l_u = (l_in > UNIT) ? UNIT : longint'(l_in);
        sq  = s_u << 8;
        lq  = l_u << 8;
        if (s_u == 0)
        begin
            // grey: every channel at lightness times full scale
            rgb_level[0] = q16_to_level(lq);
            rgb_level[1] = rgb_level[0];
            rgb_level[2] = rgb_level[0];
            return;
        end
        hq = (longint'(h_deg) << 16) / 360;
        if (lq < Q16_HALF)
            upper = (lq * (Q16_ONE + sq)) >>> 16;
        else
            upper = lq + sq - ((lq * sq) >>> 16);
        lower = 2 * lq - upper;
        rgb_level[0] = q16_to_level(hsl_channel(lower, upper, hq + Q16_THIRD));
        rgb_level[1] = q16_to_level(hsl_channel(lower, upper, hq));
        rgb_level[2] = q16_to_level(hsl_channel(lower, upper, hq - Q16_THIRD));
    endfunction

    // Advance the shadow state by one accepted request and queue its result
    function automatic void predict_pwm_step(logic cmd, logic [HUE_W-1:0] h_deg,
                                             logic [SL_W-1:0] s_in, logic [SL_W-1:0] l_in);
        rgb_result_t res;
        res.red_on   = 1'b0;
        res.green_on = 1'b0;
        res.blue_on  = 1'b0;
        if (cmd == CMD_SET_COLOR)
        begin
            mix_hsl_levels(h_deg, s_in, l_in);
        end
        else
        begin
            res.red_on   = rgb_level[0] > pwm_count;
            res.green_on = rgb_level[1] > pwm_count;
            res.blue_on  = rgb_level[2] > pwm_count;
            pwm_count    = (pwm_count + 1) & int'(FULL_SCALE);
        end
        res.red_level   = rgb_level[0][LVL_W-1:0];
        res.green_level = rgb_level[1][LVL_W-1:0];
        res.blue_level  = rgb_level[2][LVL_W-1:0];
        queued_rgb.push_back(res);
    endfunction

    // ---------------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------------

    // Offer one request and hold it until accepted. Valid stays high on return so a
    // back-to-back request never drops it; an idle gap lowers it explicitly.
    task automatic send_request(logic cmd, logic [HUE_W-1:0] h_deg,
                                logic [SL_W-1:0] s_in, logic [SL_W-1:0] l_in);
        int gap;
        in_valid   <= 1'b1;
        command    <= cmd;
        hue        <= h_deg;
        saturation <= s_in;
        lightness  <= l_in;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_pwm_step(cmd, h_deg, s_in, l_in);
        if (source_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, HUE_W'($urandom), SL_W'($urandom), SL_W'($urandom));
    endtask

    // Random set-colour request, weighted toward the in-range values and the edges
    task automatic send_random_color();
        logic [HUE_W-1:0] h_deg;
        logic [SL_W-1:0]  s_in;
        logic [SL_W-1:0]  l_in;
        h_deg = ($urandom_range(0, 4) == 0) ? HUE_W'($urandom_range(360, 511))
                                            : HUE_W'($urandom_range(0, 359));
        case ($urandom_range(0, 9))
            0:       s_in = '0;
            1:       s_in = UNIT_MAX;
            2, 3:    s_in = SL_W'($urandom_range(257, 511));
            default: s_in = SL_W'($urandom_range(1, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       l_in = '0;
            1:       l_in = UNIT_MAX;
            2:       l_in = LIG_HALF - SL_W'($urandom_range(0, 1));
            3:       l_in = SL_W'($urandom_range(257, 511));
            default: l_in = SL_W'($urandom_range(1, 255));
        endcase
        send_request(CMD_SET_COLOR, h_deg, s_in, l_in);
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (queued_rgb.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------
    // Result side: check each accepted result, then pick the next stall value
    // ---------------------------------------------------------------------------

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    int hold_left  = 0;
    int burst_left = 0;

    always @(posedge clk)
    begin
        rgb_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (queued_rgb.size() == 0)
            begin
                $display("%0t: result with nothing queued, actual R=%0d G=%0d B=%0d",
                         $time, red_level, green_level, blue_level);
                fail_count++;
            end
            else
            begin
                want = queued_rgb.pop_front();
                check_field("red_on",      want.red_on,      red_on);
                check_field("green_on",    want.green_on,    green_on);
                check_field("blue_on",     want.blue_on,     blue_on);
                check_field("red_level",   want.red_level,   red_level);
                check_field("green_level", want.green_level, green_level);
                check_field("blue_level",  want.blue_level,  blue_level);
            end
        end

        // pick up a long hold-off request and count it down here
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left--;
            out_stall <= 1'b1;
        end
        else if (sink_gaps && $urandom_range(0, 5) == 0)
        begin
            burst_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------

    // Ticks straight after reset: all levels zero, so every output stays off
    task automatic test_reset_ticks();
        repeat (3)
            send_tick();
    endtask

    // Zero saturation gives grey at lightness times full scale, out-of-range clamped
    task automatic test_grey();
        send_request(CMD_SET_COLOR, 9'd0,   '0, '0);
        send_request(CMD_SET_COLOR, 9'd200, '0, LIG_HALF);
        send_tick();
        send_request(CMD_SET_COLOR, 9'd511, '0, 9'd511);
        send_tick();
    endtask

    // Full-saturation primaries, the last legal hue and a hue past 359
    task automatic test_hue_extremes();
        send_request(CMD_SET_COLOR, 9'd0,   UNIT_MAX, LIG_HALF);
        send_tick();
        send_request(CMD_SET_COLOR, 9'd120, UNIT_MAX, LIG_HALF);
        send_request(CMD_SET_COLOR, 9'd240, UNIT_MAX, LIG_HALF);
        send_tick();
        send_request(CMD_SET_COLOR, 9'd359, UNIT_MAX, LIG_HALF);
        send_request(CMD_SET_COLOR, 9'd511, UNIT_MAX, LIG_HALF);
    endtask

    // Clamping of saturation and lightness, and both sides of the lightness half point
    task automatic test_clamp_and_half();
        send_request(CMD_SET_COLOR, 9'd200, 9'd511,   9'd64);
        send_request(CMD_SET_COLOR, 9'd30,  9'd100,   9'd511);
        send_request(CMD_SET_COLOR, 9'd90,  UNIT_MAX, LIG_HALF - 9'd1);
        send_request(CMD_SET_COLOR, 9'd90,  UNIT_MAX, LIG_HALF);
        send_request(CMD_SET_COLOR, 9'd300, 9'd1,     9'd255);
        send_tick();
    endtask

    // Mostly ticks with occasional color changes; ticks carry junk in unused fields
    task automatic test_random_mix(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                send_random_color();
            else
                send_tick();
        end
    endtask

    // Hold the receiver off for a long stretch while requests keep coming, so the
    // output register fills and the block stalls its input
    task automatic test_backpressure();
        source_gaps  = 1'b0;
        hold_request = LONG_HOLD;
        send_random_color();
        repeat (30)
            send_tick();
        source_gaps = 1'b1;
    endtask

    // Pause the sender until nothing is outstanding, then resume
    task automatic test_drain_pause();
        test_random_mix(10);
        wait_drained();
        test_random_mix(10);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_TICK;
        hue        <= '0;
        saturation <= '0;
        lightness  <= '0;
        out_stall  <= 1'b0;
        pwm_count    = 0;
        rgb_level[0] = 0;
        rgb_level[1] = 0;
        rgb_level[2] = 0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with no idling, then turn on random gaps on both sides
        test_reset_ticks();
        test_grey();
        test_hue_extremes();
        test_clamp_and_half();
        source_gaps = 1'b1;
        sink_gaps   = 1'b1;
        test_random_mix(240);
        test_backpressure();
        test_drain_pause();
        test_random_mix(240);

        // steady stream at the end: no idling on either side
        source_gaps = 1'b0;
        sink_gaps   = 1'b0;
        test_random_mix(100);

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && queued_rgb.size() == 0)
            $display("hsl_to_rgb_soft_pwm_core verification clean");
        else
            $display("hsl_to_rgb_soft_pwm_core verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/hslpwm_pkg.sv
hdl/hsl_to_rgb_soft_pwm_core.sv
hdl/hslpwm_checker.sv
tb/tb_hsl_to_rgb_soft_pwm_core.sv
